>>> hdl/hci_h4_pkg.sv
// ----------------------------------------------------------------------------
// HCI H4 deframer package
// Phase codes, H4 packet type codes, header length lookup and the result
// record shared by the deframer logic.
// ----------------------------------------------------------------------------
package hci_h4_pkg;

    // Parser phases.
    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_PAY  = 2'd2;

    // H4 packet type bytes.
    localparam logic [7:0] KIND_CMD = 8'h01;
    localparam logic [7:0] KIND_ACL = 8'h02;
    localparam logic [7:0] KIND_SCO = 8'h03;
    localparam logic [7:0] KIND_EVT = 8'h04;

    // Header lengths per packet type.
    localparam logic [2:0] HDR_LEN_CMD = 3'd3;
    localparam logic [2:0] HDR_LEN_ACL = 3'd4;
    localparam logic [2:0] HDR_LEN_SCO = 3'd3;
    localparam logic [2:0] HDR_LEN_EVT = 3'd2;

    // Reset value of the payload limit register.
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

    // One result item as it leaves the parser.
    typedef struct packed {
        logic [16:0] bytes_so_far;
        logic        aborted;
        logic        is_last;
        logic        is_first;
        logic [2:0]  packet_kind;
        logic [7:0]  out_byte;
    } res_t;

    // Header length for a type byte; zero means the byte is not a packet type.
    function automatic logic [2:0] hdr_len_of(input logic [7:0] t);
        logic [2:0] n;
        case (t)
            KIND_CMD: n = HDR_LEN_CMD;
            KIND_ACL: n = HDR_LEN_ACL;
            KIND_SCO: n = HDR_LEN_SCO;
            KIND_EVT: n = HDR_LEN_EVT;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

>>> hdl/hci_h4_uart_deframer.sv
// ----------------------------------------------------------------------------
// HCI H4 UART deframer
// Splits a raw UART byte stream into H4 packets and tags every packet byte.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel (s_tvalid/s_tready/s_tdata) takes one received UART byte
// per request. While the parser hunts for a packet start, bytes other than the
// four H4 type codes are dropped and produce nothing. Every other byte leaves
// on the master channel as one request: m_tdata carries the byte and the
// running packet length, m_tuser the packet type, the first-byte flag and the
// abort flag, and m_tlast marks the byte that completes or aborts a packet.
// An aborted packet (payload length above max_payload) must be discarded by
// the receiver; the parser then hunts for the next type byte.
// Each result is registered (output or skid register). Throughput is one byte
// per cycle while s_tready is high; all per-byte work is a few compares and
// counter updates between the input handshake and the output register.
// A two-entry output stage (output register plus skid register) keeps
// s_tready high while one result waits to be taken; s_tready drops only
// when both entries are full, so a stalled receiver backs up after two bytes.
// Reset (aresetn low, synchronous) empties the output stage, returns the
// parser to hunting and sets max_payload to 1024. cfg_we writes max_payload;
// it takes effect at the next header check.
// ----------------------------------------------------------------------------
module hci_h4_uart_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: payload length limit.
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // Received bytes.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    // Packet bytes.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] out_byte, [24:8] bytes_so_far, rest zero
    output logic        m_tlast,    // is_last
    output logic [4:0]  m_tuser     // [2:0] packet_kind, [3] is_first, [4] aborted
);
    import hci_h4_pkg::*;

    // Parser state.
    logic [15:0] max_payload_reg;
    logic [1:0]  phase_reg,          phase_next;
    logic [2:0]  kind_reg,           kind_next;
    logic [2:0]  hdr_needed_reg,     hdr_needed_next;
    logic [2:0]  hdr_count_reg,      hdr_count_next;
    logic [15:0] pay_needed_reg,     pay_needed_next;
    logic [15:0] pay_count_reg,      pay_count_next;
    logic [16:0] len_count_reg,      len_count_next;

    // Output stage: the output register and a skid entry behind it.
    logic        out_valid_reg;
    res_t        out_reg;
    logic        skid_valid_reg;
    res_t        skid_reg;

    logic        in_fire;
    logic        res_valid;
    res_t        res;
    logic        out_free;

    logic [2:0]  hdr_len;
    logic [2:0]  hdr_count_inc;
    logic [15:0] pay_count_inc;
    logic        first_flag, last_flag, abort_flag;

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign hdr_len       = hdr_len_of(s_tdata);
    assign hdr_count_inc = hdr_count_reg + 3'd1;
    assign pay_count_inc = pay_count_reg + 16'd1;

    // Per-byte parse step. Results take the kind and length as updated by
    // this byte.
    always_comb begin
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        hdr_needed_next = hdr_needed_reg;
        hdr_count_next  = hdr_count_reg;
        pay_needed_next = pay_needed_reg;
        pay_count_next  = pay_count_reg;
        len_count_next  = len_count_reg;
        res_valid       = 1'b0;
        first_flag      = 1'b0;
        last_flag       = 1'b0;
        abort_flag      = 1'b0;

        case (phase_reg)
            PH_HUNT: begin
                if (hdr_len != 3'd0) begin
                    res_valid       = 1'b1;
                    first_flag      = 1'b1;
                    kind_next       = s_tdata[2:0];
                    hdr_needed_next = hdr_len;
                    hdr_count_next  = 3'd0;
                    pay_needed_next = 16'd0;
                    pay_count_next  = 16'd0;
                    len_count_next  = 17'd1;
                    phase_next      = PH_HDR;
                end
            end
            PH_HDR: begin
                res_valid = 1'b1;
                // ACL carries a two-byte little-endian length; the others
                // carry it in the last header byte.
                if ({5'd0, kind_reg} == KIND_ACL) begin
                    if (hdr_count_reg == 3'd2) begin
                        pay_needed_next = {8'd0, s_tdata};
                    end else if (hdr_count_reg == 3'd3) begin
                        pay_needed_next = {s_tdata, pay_needed_reg[7:0]};
                    end
                end else if (hdr_count_inc == hdr_needed_reg) begin
                    pay_needed_next = {8'd0, s_tdata};
                end
                hdr_count_next = hdr_count_inc;
                len_count_next = len_count_reg + 17'd1;
                if (hdr_count_inc == hdr_needed_reg) begin
                    pay_count_next = 16'd0;
                    if (pay_needed_next > max_payload_reg) begin
                        phase_next = PH_HUNT;
                        last_flag  = 1'b1;
                        abort_flag = 1'b1;
                    end else if (pay_needed_next == 16'd0) begin
                        phase_next = PH_HUNT;
                        last_flag  = 1'b1;
                    end else begin
                        phase_next = PH_PAY;
                    end
                end
            end
            PH_PAY: begin
                res_valid      = 1'b1;
                pay_count_next = pay_count_inc;
                len_count_next = len_count_reg + 17'd1;
                if (pay_count_inc == pay_needed_reg) begin
                    phase_next = PH_HUNT;
                    last_flag  = 1'b1;
                end
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase

        res.out_byte     = s_tdata;
        res.packet_kind  = kind_next;
        res.is_first     = first_flag;
        res.is_last      = last_flag;
        res.aborted      = abort_flag;
        res.bytes_so_far = len_count_next;
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end else if (cfg_we) begin
            max_payload_reg <= cfg_wdata;
        end
    end

    // Parser state advances only on an accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            kind_reg       <= 3'd0;
            hdr_needed_reg <= 3'd0;
            hdr_count_reg  <= 3'd0;
            pay_needed_reg <= 16'd0;
            pay_count_reg  <= 16'd0;
            len_count_reg  <= 17'd0;
        end else if (in_fire) begin
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            hdr_needed_reg <= hdr_needed_next;
            hdr_count_reg  <= hdr_count_next;
            pay_needed_reg <= pay_needed_next;
            pay_count_reg  <= pay_count_next;
            len_count_reg  <= len_count_next;
        end
    end

    // Output stage. A new result goes straight to the output register when
    // it is free; otherwise it parks in the skid entry, which blocks input
    // until the output register drains it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_fire && res_valid;
            end
        end else if (in_fire && res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (in_fire) begin
                out_reg <= res;
            end
        end else if (in_fire && res_valid) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.bytes_so_far, out_reg.out_byte};
    assign m_tlast  = out_reg.is_last;
    assign m_tuser  = {out_reg.aborted, out_reg.is_first, out_reg.packet_kind};

`ifndef SYNTHESIS
    // The skid entry is only ever filled behind a held output register.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // In the header phase the count stays below the header length.
    a_hdr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HDR) |-> (hdr_count_reg < hdr_needed_reg))
        else $error("header count ran past header length");

    // The packet length is type plus header plus payload bytes so far.
    a_len_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAY) |->
            (len_count_reg == ({14'd0, hdr_needed_reg} + 17'd1 + {1'b0, pay_count_reg})))
        else $error("packet length out of step with counters");

    // A packet never runs past its announced payload length.
    a_pay_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAY) |-> (pay_count_reg < pay_needed_reg))
        else $error("payload count ran past payload length");
`endif

endmodule

>>> dv/hci_h4_uart_deframer_test.sv
// ----------------------------------------------------------------------------
// HCI H4 UART deframer testbench
// Feeds the deframer a byte stream of well-formed H4 packets, oversized headers
// and junk bytes between packets. A frame tracker inside the bench follows the
// parser state byte by byte and checks every packet byte that leaves the block.
// ----------------------------------------------------------------------------
module hci_h4_uart_deframer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import hci_h4_pkg::*;

    // Tracks the H4 framing of the accepted byte stream and holds the tagged
    // packet bytes that are still owed by the block, oldest first.
    class h4_frame_tracker;
        logic [15:0] limit;
        logic [1:0]  phase;
        logic [2:0]  kind;
        logic [2:0]  hdr_need;
        logic [2:0]  hdr_cnt;
        logic [15:0] pay_need;
        logic [15:0] pay_cnt;
        logic [16:0] len_cnt;
        res_t        owed_bytes[$];
        int          errors;

        function new();
            limit    = MAX_PAYLOAD_RESET;
            phase    = PH_HUNT;
            kind     = '0;
            hdr_need = '0;
            hdr_cnt  = '0;
            pay_need = '0;
            pay_cnt  = '0;
            len_cnt  = '0;
            errors   = 0;
        endfunction

        function void set_limit(logic [15:0] value);
            limit = value;
        endfunction

        function int pending();
            return owed_bytes.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100) begin
                $display("mismatch: %s", msg);
            end
        endtask

        // Advances the framing state by one received byte and queues the
        // tagged byte it yields, if any.
        function void note_rx_byte(logic [7:0] b);
            res_t       r;
            logic [2:0] n;
            bit         emit;
            emit       = 1'b1;
            r          = '0;
            case (phase)
                PH_HUNT: begin
                    case (b)
                        KIND_CMD: n = HDR_LEN_CMD;
                        KIND_ACL: n = HDR_LEN_ACL;
                        KIND_SCO: n = HDR_LEN_SCO;
                        KIND_EVT: n = HDR_LEN_EVT;
                        default:  n = 3'd0;
                    endcase
                    if (n == 3'd0) begin
                        emit = 1'b0;
                    end else begin
                        kind       = b[2:0];
                        hdr_need   = n;
                        hdr_cnt    = '0;
                        pay_need   = '0;
                        pay_cnt    = '0;
                        len_cnt    = 17'd1;
                        phase      = PH_HDR;
                        r.is_first = 1'b1;
                    end
                end
                PH_HDR: begin
                    // ACL carries a 16-bit little-endian length in the third and fourth
                    // header bytes; the others end with a length byte.
                    if (kind == KIND_ACL[2:0]) begin
                        if (hdr_cnt == 3'd2) begin
                            pay_need = {8'h00, b};
                        end else if (hdr_cnt == 3'd3) begin
                            pay_need = {b, pay_need[7:0]};
                        end
                    end else if (hdr_cnt + 3'd1 == hdr_need) begin
                        pay_need = {8'h00, b};
                    end
                    hdr_cnt = hdr_cnt + 3'd1;
                    len_cnt = len_cnt + 17'd1;
                    if (hdr_cnt == hdr_need) begin
                        pay_cnt = '0;
                        if (pay_need > limit) begin
                            phase     = PH_HUNT;
                            r.is_last = 1'b1;
                            r.aborted = 1'b1;
                        end else if (pay_need == 16'd0) begin
                            phase     = PH_HUNT;
                            r.is_last = 1'b1;
                        end else begin
                            phase = PH_PAY;
                        end
                    end
                end
                PH_PAY: begin
                    pay_cnt = pay_cnt + 16'd1;
                    len_cnt = len_cnt + 17'd1;
                    if (pay_cnt == pay_need) begin
                        phase     = PH_HUNT;
                        r.is_last = 1'b1;
                    end
                end
                default: begin
                    phase = PH_HUNT;
                    emit  = 1'b0;
                end
            endcase
            if (emit) begin
                r.out_byte     = b;
                r.packet_kind  = kind;
                r.bytes_so_far = len_cnt;
                owed_bytes.push_back(r);
            end
        endfunction

        task check_packet_byte(res_t got);
            res_t want;
            if (owed_bytes.size() == 0) begin
                report($sformatf("unexpected byte %h kind %0d first %b last %b abort %b len %0d",
                                 got.out_byte, got.packet_kind, got.is_first,
                                 got.is_last, got.aborted, got.bytes_so_far));
            end else begin
                want = owed_bytes.pop_front();
                if (got !== want) begin
                    report($sformatf({"got byte %h kind %0d first %b last %b abort %b len %0d,",
                                      " want byte %h kind %0d first %b last %b abort %b len %0d"},
                                     got.out_byte, got.packet_kind, got.is_first,
                                     got.is_last, got.aborted, got.bytes_so_far,
                                     want.out_byte, want.packet_kind, want.is_first,
                                     want.is_last, want.aborted, want.bytes_so_far));
                end
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [7:0] out_byte, [24:8] bytes_so_far, rest zero
    logic        m_tlast;           // is_last
    logic [4:0]  m_tuser;           // [2:0] packet_kind, [3] is_first, [4] aborted

    // Percent of cycles in which each side holds back.
    int send_idle = 0;
    int recv_idle = 0;
    int sent_cnt = 0;

    h4_frame_tracker tracker = new();

    hci_h4_uart_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // The clock runs with a 20 ns period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // The receiver decides at each falling edge whether it takes a request
    // in the coming cycle.
    initial begin
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(99) >= recv_idle);
        end
    end

    // Every request taken at a rising edge is compared with the oldest owed
    // packet byte. Values read here are the ones that the edge sampled.
    always @(posedge aclk) begin
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.out_byte     = m_tdata[7:0];
            got.bytes_so_far = m_tdata[24:8];
            got.packet_kind  = m_tuser[2:0];
            got.is_first     = m_tuser[3];
            got.aborted      = m_tuser[4];
            got.is_last      = m_tlast;
            tracker.check_packet_byte(got);
        end
    end

    // Offers one byte, with random idle cycles in front of it, and returns
    // once the block has accepted it. The valid line stays high between
    // back-to-back bytes, so it is never dropped and raised in one step.
    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        tracker.note_rx_byte(b);
        sent_cnt++;
    endtask

    // Holds the sender back until every owed byte has come out. A dropped
    // junk byte leaves nothing to wait for, so the task then also lets the
    // output register of the block settle.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Writes the payload limit while no request is in flight.
    task automatic write_limit(input logic [15:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        tracker.set_limit(value);
    endtask

    // Chooses a payload length for a packet of the given type. Most lengths
    // are short; some sit exactly at the limit, some exceed it so that the
    // header aborts, and a few are between 41 and 300 bytes long.
    function automatic int pick_len(input logic [7:0] kind, input int limit);
        int cap;
        int roll;
        int n;
        cap  = (kind == KIND_ACL) ? 65535 : 255;
        roll = $urandom_range(99);
        if (roll < 8) begin
            n = 0;
        end else if (roll < 16 && limit <= 300) begin
            n = (limit < cap) ? limit : cap;
        end else if (roll < 30 && limit < cap) begin
            n = $urandom_range(cap, limit + 1);
        end else if (roll < 33) begin
            n = $urandom_range(300, 41);
        end else begin
            n = $urandom_range(24, 1);
        end
        if (n > cap) begin
            n = cap;
        end
        return n;
    endfunction

    // Sends a complete H4 packet: type byte, header with random fields and
    // the length, then the payload unless the header ends the packet.
    task automatic send_packet(input logic [7:0] kind, input int len);
        logic [15:0] n16;
        n16 = len[15:0];
        send_byte(kind);
        case (kind)
            KIND_CMD, KIND_SCO: begin
                send_byte(8'($urandom_range(255)));
                send_byte(8'($urandom_range(255)));
                send_byte(n16[7:0]);
            end
            KIND_ACL: begin
                send_byte(8'($urandom_range(255)));
                send_byte(8'($urandom_range(255)));
                send_byte(n16[7:0]);
                send_byte(n16[15:8]);
            end
            default: begin
                send_byte(8'($urandom_range(255)));
                send_byte(n16[7:0]);
            end
        endcase
        if (len != 0 && len <= tracker.limit) begin
            repeat (len) send_byte(8'($urandom_range(255)));
        end
    endtask

    // Directed opening: junk bytes at both ends of the byte range, an event
    // with no payload, a command and an ACL packet with payload bytes at the
    // extremes, an SCO header with zero length, and an ACL header whose limit
    // is lowered halfway through the header so that it aborts.
    logic [7:0] opening [] = '{
        8'h00, 8'hFF,
        KIND_EVT, 8'h0E, 8'h00,
        KIND_CMD, 8'h03, 8'h0C, 8'h01, 8'hFF,
        KIND_ACL, 8'h01, 8'h20, 8'h02, 8'h00, 8'h00, 8'h80,
        KIND_SCO, 8'h55, 8'hAA, 8'h00,
        KIND_ACL, 8'h00, 8'hFF
    };

    initial begin
        logic [15:0] seg_limit [5];
        logic [7:0]  junk;
        logic [7:0]  kind;
        int          seg;
        int          goal;

        seg_limit[0] = 16'hFFFF;
        seg_limit[1] = 16'h0000;
        seg_limit[2] = 16'($urandom_range(64, 1));
        seg_limit[3] = MAX_PAYLOAD_RESET;
        seg_limit[4] = 16'd255;

        // Reset is held, then released at a falling edge.
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle = 14;
        recv_idle = 77;
        foreach (opening[i]) begin
            send_byte(opening[i]);
        end
        // The limit changes while the ACL header is half received; the
        // length of four that follows is then checked against the new limit.
        write_limit(16'd3);
        send_byte(8'h04);
        send_byte(8'h00);

        // Random part: well-formed packets with random content and lengths,
        // oversized headers, and short bursts of junk between packets. Each
        // segment starts from an idle block with its own limit, which also
        // makes the sender pause until every owed byte has come.
        for (seg = 0; seg < 5; seg++) begin
            write_limit(seg_limit[seg]);
            if (seg < 2) begin
                send_idle = 14;
                recv_idle = 77;
            end else if (seg < 4) begin
                send_idle = 77;
                recv_idle = 14;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            goal = sent_cnt + 300;
            while (sent_cnt < goal) begin
                if ($urandom_range(99) < 20) begin
                    repeat ($urandom_range(3, 1)) begin
                        do junk = 8'($urandom_range(255));
                        while (junk >= KIND_CMD && junk <= KIND_EVT);
                        send_byte(junk);
                    end
                end
                kind = 8'($urandom_range(KIND_EVT, KIND_CMD));
                send_packet(kind, pick_len(kind, int'(tracker.limit)));
            end
        end

        wait_drained();
        repeat (5) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> hci_h4_uart_deframer.f
hdl/hci_h4_pkg.sv
hdl/hci_h4_uart_deframer.sv
dv/hci_h4_uart_deframer_test.sv
